/* sv/tlbfs_pkg.sv */
// Package: request/response types, operation and status codes for the two-layer BFS block.
`default_nettype none
package tlbfs_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // register byte offsets
  localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

  localparam logic [6:0] VERTEX_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]  operation;
    logic        layer;
    logic [5:0]  from_vertex;
    logic [5:0]  to_vertex;
    logic [63:0] bridge_mask;
  } in_req_t;

  typedef struct packed {
    logic       reachable;
    logic [1:0] status;
  } out_rsp_t;

endpackage
`default_nettype wire

/* sv/two_layer_bfs_reachability_top.sv */
// Top level: two-layer graph store with a memory-based breadth-first reachability search.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | in_req  (tlbfs_pkg::in_req_t)
//  out_    | output    | out_valid / out_ready | out_rsp (tlbfs_pkg::out_rsp_t)
//  cfg_    | input     | APB psel/penable      | vertex_count at offset 0
//
// Clear, unused codes and rejected requests are answered from idle; add-edge reads the
// degree, then writes the edge in S_ADD. A query expands each node it reaches in turn,
// reading every stored edge: one adjacency-memory read per cycle sets the pace.
// One request is in flight at a time; a finished response waits in the output
// register, and the next request is taken once that register is free or drains.
// Synchronous active-low reset clears degree-valid bits, visited marks and control.
`default_nettype none
module two_layer_bfs_reachability_top #(
  parameter int LAYER_VERTICES = 64,
  parameter int MAX_DEGREE     = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tlbfs_pkg::in_req_t in_req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tlbfs_pkg::out_rsp_t     out_rsp,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int NODE_COUNT = 2 * LAYER_VERTICES;
  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int AW = NW + SW;
  localparam int ADJ_DEPTH = NODE_COUNT << SW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD      = 3'd1;
  localparam logic [2:0] S_POP      = 3'd2;
  localparam logic [2:0] S_POP_WAIT = 3'd3;
  localparam logic [2:0] S_DEG_WAIT = 3'd4;
  localparam logic [2:0] S_EDGE     = 3'd5;
  localparam logic [2:0] S_BRIDGE   = 3'd6;

  // memories
  logic [NW-1:0] adj_mem [ADJ_DEPTH];
  logic [DW-1:0] deg_mem [NODE_COUNT];
  logic [NW-1:0] queue_mem [NODE_COUNT];

  logic [2:0]            state_r, state_nxt;
  logic [6:0]            vcount_r;
  tlbfs_pkg::in_req_t    req_r;
  logic [NODE_COUNT-1:0] deg_valid_r;
  logic [NODE_COUNT-1:0] visited_r;
  logic [NW:0]           head_r, head_nxt, tail_r;
  logic [NW-1:0]         v_r, v_nxt;
  logic [DW-1:0]         deg_r, deg_nxt, slot_r, slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  tlbfs_pkg::out_rsp_t   out_rsp_r, out_rsp_nxt;

  logic [NW-1:0] adj_rdata_r, queue_rdata_r;
  logic [DW-1:0] deg_rdata_r;

  logic          adj_re, deg_re, queue_re, adj_we, deg_we, deg_clear;
  logic [AW-1:0] adj_raddr, adj_waddr;
  logic [NW-1:0] adj_wdata, deg_raddr, deg_waddr;
  logic [DW-1:0] deg_wdata;
  logic          visit_en, start_en;
  logic [NW-1:0] visit_node;

  logic          accept, slot_free, in_range;
  logic [6:0]    n_used;
  logic [NW-1:0] src_node, dst_node, start_node, target_node, bridge_z, partner;
  logic [DW-1:0] deg_cur, slot_inc;

  // effective vertex count
  assign n_used = (vcount_r > 7'(LAYER_VERTICES)) ? 7'(LAYER_VERTICES) : vcount_r;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign in_range  = (7'(in_req.from_vertex) < n_used) && (7'(in_req.to_vertex) < n_used);

  // node numbers for the request being accepted and the one in flight
  assign src_node    = in_req.layer ? NW'(LAYER_VERTICES) + NW'(in_req.from_vertex)
                                    : NW'(in_req.from_vertex);
  assign dst_node    = req_r.layer ? NW'(LAYER_VERTICES) + NW'(req_r.to_vertex)
                                   : NW'(req_r.to_vertex);
  assign start_node  = NW'(in_req.from_vertex);
  assign target_node = NW'(LAYER_VERTICES) + NW'(req_r.to_vertex);

  // bridge partner of the node being expanded
  assign bridge_z = (v_r < NW'(LAYER_VERTICES)) ? v_r : v_r - NW'(LAYER_VERTICES);
  assign partner  = (v_r < NW'(LAYER_VERTICES)) ? v_r + NW'(LAYER_VERTICES) : bridge_z;

  assign deg_cur  = deg_valid_r[v_r] ? deg_rdata_r : '0;
  assign slot_inc = slot_r + DW'(1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    v_nxt         = v_r;
    deg_nxt       = deg_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    adj_re = 1'b0; adj_raddr = '0;
    deg_re = 1'b0; deg_raddr = '0;
    queue_re = 1'b0;
    adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0;
    deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0;
    deg_clear = 1'b0;
    visit_en = 1'b0; visit_node = '0;
    start_en = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_rsp_nxt = '{reachable: 1'b0, status: tlbfs_pkg::STATUS_OK};
          case (in_req.operation)
            tlbfs_pkg::OP_CLEAR: begin
              deg_clear     = 1'b1;
              out_valid_nxt = 1'b1;
            end
            tlbfs_pkg::OP_ADD: begin
              if (!in_range) begin
                out_rsp_nxt.status = tlbfs_pkg::STATUS_RANGE;
                out_valid_nxt      = 1'b1;
              end else begin
                deg_re    = 1'b1;
                deg_raddr = src_node;
                v_nxt     = src_node;
                state_nxt = S_ADD;
              end
            end
            tlbfs_pkg::OP_QUERY: begin
              if (!in_range) begin
                out_rsp_nxt.status = tlbfs_pkg::STATUS_RANGE;
                out_valid_nxt      = 1'b1;
              end else begin
                start_en  = 1'b1;
                head_nxt  = '0;
                state_nxt = S_POP;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_ADD: begin
        if (deg_cur >= DW'(MAX_DEGREE)) begin
          out_rsp_nxt.status = tlbfs_pkg::STATUS_FULL;
        end else begin
          adj_we    = 1'b1;
          adj_waddr = {v_r, SW'(deg_cur)};
          adj_wdata = dst_node;
          deg_we    = 1'b1;
          deg_waddr = v_r;
          deg_wdata = deg_cur + DW'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_POP: begin
        if (head_r == tail_r) begin
          if (slot_free) begin
            out_rsp_nxt.reachable = visited_r[target_node];
            out_valid_nxt         = 1'b1;
            state_nxt             = S_IDLE;
          end
        end else begin
          queue_re  = 1'b1;
          head_nxt  = head_r + 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        v_nxt     = queue_rdata_r;
        deg_re    = 1'b1;
        deg_raddr = queue_rdata_r;
        state_nxt = S_DEG_WAIT;
      end
      S_DEG_WAIT: begin
        deg_nxt  = deg_cur;
        slot_nxt = '0;
        if (deg_cur != '0) begin
          adj_re    = 1'b1;
          adj_raddr = {v_r, SW'(0)};
          state_nxt = S_EDGE;
        end else begin
          state_nxt = S_BRIDGE;
        end
      end
      S_EDGE: begin
        visit_en   = 1'b1;
        visit_node = adj_rdata_r;
        if (slot_inc < deg_r) begin
          adj_re    = 1'b1;
          adj_raddr = {v_r, SW'(slot_inc)};
          slot_nxt  = slot_inc;
        end else begin
          state_nxt = S_BRIDGE;
        end
      end
      S_BRIDGE: begin
        visit_en   = (7'(bridge_z) < n_used) && req_r.bridge_mask[6'(bridge_z)];
        visit_node = partner;
        state_nxt  = S_POP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      deg_valid_r <= '0;
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      vcount_r    <= tlbfs_pkg::VERTEX_COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == tlbfs_pkg::REG_VERTEX_COUNT[2]) begin
        vcount_r <= cfg_pwdata[6:0];
      end
      if (deg_clear) begin
        deg_valid_r <= '0;
      end else if (deg_we) begin
        deg_valid_r[deg_waddr] <= 1'b1;
      end
      // a new search leaves only the start node marked
      if (start_en) begin
        visited_r <= {{(NODE_COUNT-1){1'b0}}, 1'b1} << start_node;
        tail_r    <= (NW+1)'(1);
      end else if (visit_en && !visited_r[visit_node] && tail_r < (NW+1)'(NODE_COUNT)) begin
        visited_r[visit_node] <= 1'b1;
        tail_r                <= tail_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    deg_r     <= deg_nxt;
    slot_r    <= slot_nxt;
    out_rsp_r <= out_rsp_nxt;
    if (accept) begin
      req_r <= in_req;
    end
  end

  // adjacency memory
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata_r <= adj_mem[adj_raddr];
    end
  end

  // degree memory; entries without a valid bit read as zero
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (deg_re) begin
      deg_rdata_r <= deg_mem[deg_raddr];
    end
  end

  // search queue
  always_ff @(posedge clk) begin
    if (start_en) begin
      queue_mem[0] <= start_node;
    end else if (visit_en && !visited_r[visit_node] && tail_r < (NW+1)'(NODE_COUNT)) begin
      queue_mem[tail_r[NW-1:0]] <= visit_node;
    end
    if (queue_re) begin
      queue_rdata_r <= queue_mem[head_r[NW-1:0]];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rsp    = out_rsp_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == tlbfs_pkg::REG_VERTEX_COUNT[2]) ?
                      {25'd0, vcount_r} : 32'd0;

  // a clear request leaves no degree valid
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.operation == tlbfs_pkg::OP_CLEAR) |=> (deg_valid_r == '0))
    else $error("degree valid bits survive a clear");

  // queue head never passes its tail
  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= tail_r) && (tail_r <= (NW+1)'(NODE_COUNT)))
    else $error("search queue pointers out of order");

  // rejected or failed requests never report reachability
  a_reject_unreached: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status != tlbfs_pkg::STATUS_OK) |-> !out_rsp_r.reachable)
    else $error("reachable set on an error response");

  // queue length equals number of visited nodes during a search
  a_visited_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> ($countones(visited_r) == int'(tail_r)))
    else $error("visited marks and queue length disagree");

endmodule
`default_nettype wire
